>>> hdl/otk_pkg.sv
// shared types and constants for the obj text tokenizer
package otk_pkg;

  localparam int IDENT_KEEP_BYTES_DEF = 8;

  // token queue between the lexer and the output channel (power of two)
  localparam int TOK_FIFO_DEPTH = 8;
  localparam int LEVEL_W = $clog2(TOK_FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    KIND_END        = 3'd0,
    KIND_NEWLINE    = 3'd1,
    KIND_SLASH      = 3'd2,
    KIND_IDENT      = 3'd3,
    KIND_INT        = 3'd4,
    KIND_FLOAT      = 3'd5,
    KIND_BAD_CHAR   = 3'd6,
    KIND_BAD_NUMBER = 3'd7
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t          kind;
    logic               is_negative;
    logic [62:0]        mantissa;
    logic [7:0]         fraction_digits;
    logic signed [14:0] exponent_value;
    logic [63:0]        ident_bytes;
    logic [7:0]         ident_length;
    logic [23:0]        line_number;
    logic [15:0]        column_number;
    logic               last_of_run;
  } token_t;

  // up to two tokens produced by one byte, in order
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } tok_push_t;

endpackage

>>> hdl/otk_ifs.sv
// valid/ready channel interfaces for text bytes and tokens
interface otk_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, in_byte, end_of_input, input ready);
  modport sink (input valid, in_byte, end_of_input, output ready);
endinterface

interface otk_token_if;
  logic               valid;
  logic               ready;
  logic [2:0]         token_kind;
  logic               is_negative;
  logic [62:0]        mantissa;
  logic [7:0]         fraction_digits;
  logic signed [14:0] exponent_value;
  logic [63:0]        ident_bytes;
  logic [7:0]         ident_length;
  logic [23:0]        line_number;
  logic [15:0]        column_number;
  logic               last_of_run;

  modport source (output valid, token_kind, is_negative, mantissa, fraction_digits,
                  exponent_value, ident_bytes, ident_length, line_number,
                  column_number, last_of_run, input ready);
  modport sink (input valid, token_kind, is_negative, mantissa, fraction_digits,
                exponent_value, ident_bytes, ident_length, line_number,
                column_number, last_of_run, output ready);
endinterface

>>> hdl/otk_lexer.sv
// byte input register, scanner state and per-byte token generation
module otk_lexer #(
  parameter int IDENT_KEEP_BYTES = otk_pkg::IDENT_KEEP_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  otk_byte_if.sink                     text,
  input  logic [otk_pkg::LEVEL_W-1:0]  level,
  output otk_pkg::tok_push_t           push
);
  import otk_pkg::*;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_VT      = 8'h0B;
  localparam logic [7:0] CH_FF      = 8'h0C;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_POINT   = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_E_UP    = 8'h45;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_E_LO    = 8'h65;

  localparam logic [62:0] MANT_MAX = {63{1'b1}};
  localparam logic [13:0] EXP_MAX  = 14'd9999;
  localparam logic [23:0] LINE_MAX = {24{1'b1}};
  localparam logic [15:0] COL_MAX  = {16{1'b1}};
  localparam logic [7:0]  CNT_MAX  = {8{1'b1}};

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_COMMENT, MODE_IDENT, MODE_NUMBER, MODE_HALT
  } mode_t;

  typedef struct packed {
    logic is_float;
    logic has_sign;
    logic has_exp;
    logic exp_neg;
    logic neg;
    logic valid;
  } num_flags_t;

  typedef struct packed {
    num_flags_t  flags;
    logic [62:0] mant;
    logic [7:0]  frac;
    logic [13:0] expo;
  } num_t;

  typedef struct packed {
    logic taken;
    num_t num;
  } num_step_t;

  typedef logic [IDENT_KEEP_BYTES-1:0][7:0] ident_buf_t;

  // character classes
  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR;
  endfunction

  // one byte offered to a number; flags may change even when the byte is refused
  function automatic num_step_t num_take(num_t s, logic [7:0] c);
    num_step_t   r;
    logic [3:0]  d;
    logic [66:0] prod;
    logic [16:0] ev;
    r.taken = 1'b1;
    r.num   = s;
    d       = c[3:0];
    prod    = ({4'd0, s.mant} << 3) + ({4'd0, s.mant} << 1) + {63'd0, d};
    ev      = ({3'd0, s.expo} << 3) + ({3'd0, s.expo} << 1) + {13'd0, d};
    if (c == CH_POINT) begin
      r.num.flags.valid = 1'b0;
      if (s.flags.is_float) r.taken = 1'b0;
      else r.num.flags.is_float = 1'b1;
    end else if (c == CH_MINUS || c == CH_PLUS) begin
      r.num.flags.valid = 1'b0;
      if (s.flags.has_sign) begin
        r.taken = 1'b0;
      end else begin
        if (c == CH_MINUS) begin
          if (s.flags.has_exp) r.num.flags.exp_neg = 1'b1;
          else r.num.flags.neg = 1'b1;
        end
        r.num.flags.has_sign = 1'b1;
      end
    end else if (c == CH_E_UP || c == CH_E_LO) begin
      r.num.flags.valid = 1'b0;
      if (s.flags.has_exp) begin
        r.taken = 1'b0;
      end else begin
        r.num.flags.is_float = 1'b1;
        r.num.flags.has_exp  = 1'b1;
        r.num.flags.has_sign = 1'b0;
      end
    end else if (is_digit(c)) begin
      r.num.flags.valid = 1'b1;
      if (s.flags.has_exp) begin
        r.num.expo = (ev > 17'd9999) ? EXP_MAX : ev[13:0];
      end else begin
        r.num.mant = (prod > {4'd0, MANT_MAX}) ? MANT_MAX : prod[62:0];
        if (s.flags.is_float && s.frac != CNT_MAX) r.num.frac = s.frac + 8'd1;
      end
    end else begin
      r.taken = 1'b0;
    end
    return r;
  endfunction

  // token builders
  function automatic token_t simple_tok(tok_kind_t k, logic [23:0] ln, logic [15:0] cl);
    token_t t;
    t               = '0;
    t.kind          = k;
    t.line_number   = ln;
    t.column_number = cl;
    return t;
  endfunction

  function automatic token_t num_tok(num_t n, logic [23:0] ln, logic [15:0] cl);
    token_t t;
    t = simple_tok(KIND_BAD_NUMBER, ln, cl);
    if (n.flags.valid) begin
      t.is_negative = n.flags.neg;
      t.mantissa    = n.mant;
      if (n.flags.is_float) begin
        t.kind            = KIND_FLOAT;
        t.fraction_digits = n.frac;
        t.exponent_value  = n.flags.exp_neg ? -{1'b0, n.expo} : {1'b0, n.expo};
      end else begin
        t.kind = KIND_INT;
      end
    end
    return t;
  endfunction

  function automatic token_t ident_tok(ident_buf_t b, logic [7:0] len, logic [23:0] ln,
                                       logic [15:0] cl);
    token_t t;
    t              = simple_tok(KIND_IDENT, ln, cl);
    t.ident_bytes  = 64'(b);
    t.ident_length = len;
    return t;
  endfunction

  // input register and scanner state
  logic        item_q;
  logic [7:0]  byte_q;
  logic        eoi_q;
  mode_t       mode, mode_next;
  num_t        num, num_next;
  ident_buf_t  ident_buf, ident_buf_next;
  logic [7:0]  ident_count, ident_count_next;
  logic [23:0] line_count, line_next;
  logic [15:0] column_count, col_next;

  logic [23:0] line_sat;
  logic [15:0] col_sat;
  num_step_t   step, start;
  token_t      ended, fresh, tok_a, tok_b;
  logic        ended_ok, fresh_ok, start_idle;
  logic [LEVEL_W:0] need;

  // room for this byte's tokens on top of those the byte in flight may write
  assign need = (LEVEL_W+1)'(level) + ((LEVEL_W+1)'(item_q) << 1) + (LEVEL_W+1)'(2);
  assign text.ready = need <= (LEVEL_W+1)'(TOK_FIFO_DEPTH);

  assign line_sat = (line_count == LINE_MAX) ? line_count : line_count + 24'd1;
  assign col_sat  = (column_count == COL_MAX) ? column_count : column_count + 16'd1;
  assign step     = num_take(num, byte_q);
  assign start    = num_take('0, byte_q);

  // next state and tokens for the registered byte
  always_comb begin
    mode_next        = mode;
    num_next         = num;
    ident_buf_next   = ident_buf;
    ident_count_next = ident_count;
    line_next        = line_count;
    col_next         = column_count;
    ended            = '0;
    ended_ok         = 1'b0;
    fresh            = '0;
    fresh_ok         = 1'b0;
    start_idle       = 1'b0;
    if (eoi_q) begin
      if (mode == MODE_IDENT) begin
        ended    = ident_tok(ident_buf, ident_count, line_count, column_count);
        ended_ok = 1'b1;
      end else if (mode == MODE_NUMBER) begin
        ended    = num_tok(num, line_count, column_count);
        ended_ok = 1'b1;
      end
      fresh            = simple_tok(KIND_END, line_count, column_count);
      fresh_ok         = 1'b1;
      mode_next        = MODE_IDLE;
      num_next         = '0;
      ident_buf_next   = '0;
      ident_count_next = '0;
      line_next        = '0;
      col_next         = '0;
    end else begin
      case (mode)
        MODE_HALT: begin
        end
        MODE_COMMENT: begin
          if (byte_q == CH_NEWLINE) begin
            line_next = line_sat;
            col_next  = '0;
            mode_next = MODE_IDLE;
          end
        end
        MODE_IDENT: begin
          if (is_letter(byte_q) || is_digit(byte_q) || byte_q == CH_UNDER) begin
            for (int i = 0; i < IDENT_KEEP_BYTES; i++) begin
              if (ident_count == 8'(i)) ident_buf_next[i] = byte_q;
            end
            if (ident_count != CNT_MAX) ident_count_next = ident_count + 8'd1;
            col_next = col_sat;
          end else begin
            ended      = ident_tok(ident_buf, ident_count, line_count, column_count);
            ended_ok   = 1'b1;
            mode_next  = MODE_IDLE;
            start_idle = 1'b1;
          end
        end
        MODE_NUMBER: begin
          num_next = step.num;
          if (step.taken) begin
            col_next = col_sat;
          end else begin
            ended    = num_tok(step.num, line_count, column_count);
            ended_ok = 1'b1;
            if (step.num.flags.valid) begin
              mode_next  = MODE_IDLE;
              start_idle = 1'b1;
            end else begin
              mode_next = MODE_HALT;
            end
          end
        end
        default: begin
          start_idle = 1'b1;
        end
      endcase

      // byte that opens something new
      if (start_idle) begin
        if (byte_q == CH_NEWLINE) begin
          line_next = line_sat;
          col_next  = '0;
          fresh     = simple_tok(KIND_NEWLINE, line_sat, '0);
          fresh_ok  = 1'b1;
        end else if (is_blank(byte_q)) begin
          col_next = col_sat;
        end else if (byte_q == CH_SLASH) begin
          col_next = col_sat;
          fresh    = simple_tok(KIND_SLASH, line_count, col_sat);
          fresh_ok = 1'b1;
        end else if (byte_q == CH_HASH) begin
          mode_next = MODE_COMMENT;
        end else if (is_letter(byte_q) || byte_q == CH_UNDER) begin
          mode_next         = MODE_IDENT;
          ident_buf_next    = '0;
          ident_buf_next[0] = byte_q;
          ident_count_next  = 8'd1;
          col_next          = col_sat;
        end else if (is_digit(byte_q) || byte_q == CH_MINUS || byte_q == CH_PLUS ||
                     byte_q == CH_POINT) begin
          mode_next = MODE_NUMBER;
          num_next  = start.num;
          col_next  = col_sat;
        end else begin
          fresh     = simple_tok(KIND_BAD_CHAR, line_count, column_count);
          fresh_ok  = 1'b1;
          mode_next = MODE_HALT;
        end
      end
    end
  end

  // order the tokens and mark the last one
  always_comb begin
    tok_a = ended_ok ? ended : fresh;
    tok_b = fresh;
    tok_a.last_of_run = !(ended_ok && fresh_ok);
    tok_b.last_of_run = 1'b1;
    push.count  = item_q ? (2'(ended_ok) + 2'(fresh_ok)) : 2'd0;
    push.first  = tok_a;
    push.second = tok_b;
  end

  // input register and state update
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q       <= 1'b0;
      mode         <= MODE_IDLE;
      num          <= '0;
      ident_buf    <= '0;
      ident_count  <= '0;
      line_count   <= '0;
      column_count <= '0;
    end else begin
      item_q <= text.valid && text.ready;
      if (item_q) begin
        mode         <= mode_next;
        num          <= num_next;
        ident_buf    <= ident_buf_next;
        ident_count  <= ident_count_next;
        line_count   <= line_next;
        column_count <= col_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      byte_q <= text.in_byte;
      eoi_q  <= text.end_of_input;
    end
  end

  // end of input always leaves a fresh scanner behind
  a_eoi_clears: assert property (@(posedge clk) disable iff (rst)
    item_q && eoi_q |=> mode == MODE_IDLE && line_count == '0 && column_count == '0)
    else $error("state not cleared after end of input");

  // a halted scanner stays silent until end of input
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    item_q && !eoi_q && mode == MODE_HALT |-> push.count == 2'd0)
    else $error("token produced while halted");

  // end of input always yields at least the end token
  a_eoi_token: assert property (@(posedge clk) disable iff (rst)
    item_q && eoi_q |-> push.count != 2'd0 && push.count != 2'd3)
    else $error("end of input without end token");

  // only the final token of a pair carries the last flag
  a_last_order: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.second.last_of_run && !push.first.last_of_run)
    else $error("last flag misplaced in token pair");

endmodule

>>> hdl/otk_token_fifo.sv
// token queue that takes up to two tokens a cycle and releases one when the receiver is ready
module otk_token_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  otk_pkg::tok_push_t           push,
  output logic [otk_pkg::LEVEL_W-1:0]  level,
  otk_token_if.source                  tokens
);
  import otk_pkg::*;

  localparam int PTR_W = $clog2(TOK_FIFO_DEPTH);

  token_t             slots [TOK_FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [LEVEL_W-1:0] count;
  logic               pop;
  token_t             head;

  assign pop   = tokens.valid && tokens.ready;
  assign level = count;
  assign head  = slots[rd_ptr];

  // output channel driven from the head slot
  assign tokens.valid           = count != '0;
  assign tokens.token_kind      = head.kind;
  assign tokens.is_negative     = head.is_negative;
  assign tokens.mantissa        = head.mantissa;
  assign tokens.fraction_digits = head.fraction_digits;
  assign tokens.exponent_value  = head.exponent_value;
  assign tokens.ident_bytes     = head.ident_bytes;
  assign tokens.ident_length    = head.ident_length;
  assign tokens.line_number     = head.line_number;
  assign tokens.column_number   = head.column_number;
  assign tokens.last_of_run     = head.last_of_run;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push.count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + LEVEL_W'(push.count) - LEVEL_W'(pop);
    end
  end

  // token storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) slots[wr_ptr] <= push.first;
    if (push.count == 2'd2) slots[wr_ptr + PTR_W'(1)] <= push.second;
  end

  // the lexer's reservation must keep every write in bounds
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> ((LEVEL_W+1)'(count) + (LEVEL_W+1)'(push.count)) <=
                           (LEVEL_W+1)'(TOK_FIFO_DEPTH))
    else $error("token queue overflow");

  // a write into an empty queue shows up on the next cycle
  a_empty_fill: assert property (@(posedge clk) disable iff (rst)
    count == '0 && push.count != 2'd0 |=> tokens.valid)
    else $error("written token not presented");

  // level drops by one on a read without a write
  a_level_track: assert property (@(posedge clk) disable iff (rst)
    pop && push.count == 2'd0 |=> count == $past(count) - LEVEL_W'(1))
    else $error("fill level out of step");

endmodule

>>> hdl/obj_text_tokenizer_unit.sv
// top level of the obj text tokenizer
//
// Channel text carries one character per transaction (in_byte) or an end
// marker (end_of_input). Channel tokens carries one token per transaction with
// its kind, number fields, identifier fields, line and column, and
// last_of_run on the final token that a byte gives.
// The accepted byte is held in an input register; in the next cycle the
// scanner logic updates its state and writes zero, one or two tokens into an
// eight-entry token queue, whose head drives the tokens channel.
// A token is valid once its byte has passed the input register and has been
// written into the token queue.
// Throughput: one byte per cycle while text.ready is high; a byte that gives
// two tokens needs two output transactions, so a run of those is limited by
// the token channel.
// text.ready depends on the queue level and on the registered byte: it is
// high while the queue can hold two more tokens beyond those that byte may
// write. When the receiver stalls the queue fills and text.ready falls;
// nothing is lost. Reset (synchronous, active high) empties the queue and
// returns the scanner to line 0, column 0, between tokens. An end marker
// returns the scanner there after its tokens but does not empty the queue.
module obj_text_tokenizer_unit #(
  parameter int IDENT_KEEP_BYTES = otk_pkg::IDENT_KEEP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  otk_byte_if.sink    text,
  otk_token_if.source tokens
);
  import otk_pkg::*;

  tok_push_t          push;
  logic [LEVEL_W-1:0] level;

  // scanner with its input register
  otk_lexer #(
    .IDENT_KEEP_BYTES(IDENT_KEEP_BYTES)
  ) u_lexer (
    .clk   (clk),
    .rst   (rst),
    .text  (text),
    .level (level),
    .push  (push)
  );

  // token queue toward the receiver
  otk_token_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .level  (level),
    .tokens (tokens)
  );

endmodule
